[rtl/core/b64e_pkg.sv]
// Package for the Base64 stream encoder.
// Holds the item and job types, the alphabet table and the character constants.
// Depends on nothing else.
package b64e_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_item_t;

  // One classified byte: up to four ready ASCII characters, the index of the
  // last one, and whether that last one ends the message.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
    logic            ends_msg;
  } job_t;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam logic [0:63][7:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  function automatic logic [7:0] b64_char(input logic [5:0] code);
    return ALPHABET[code];
  endfunction

endpackage

[rtl/core/b64e_front.sv]
// Front end of the Base64 stream encoder: tracks the group phase and carry
// bits and turns each accepted byte into a job of ready characters.
// Depends on b64e_pkg.
module b64e_front import b64e_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_item_t din,
  input  logic     q_full,
  output logic     q_push,
  output job_t     q_job
);

  phase_t     phase, phase_next;
  logic [3:0] carry, carry_next;
  logic [7:0] b;

  assign b      = din.data_byte;
  assign q_push = push && !q_full;

  always_comb begin
    q_job      = '0;
    phase_next = PH_START;
    carry_next = '0;
    case (phase)
      PH_SECOND: begin
        q_job.chars[0] = b64_char({carry[1:0], b[7:4]});
        if (din.final_byte) begin
          q_job.chars[1] = b64_char({b[3:0], 2'b00});
          q_job.chars[2] = PAD_CHAR;
          q_job.last_idx = 2'd2;
          q_job.ends_msg = 1'b1;
        end else begin
          q_job.last_idx = 2'd0;
          phase_next     = PH_THIRD;
          carry_next     = b[3:0];
        end
      end
      PH_THIRD: begin
        q_job.chars[0] = b64_char({carry, b[7:6]});
        q_job.chars[1] = b64_char(b[5:0]);
        q_job.last_idx = 2'd1;
        q_job.ends_msg = din.final_byte;
      end
      default: begin
        q_job.chars[0] = b64_char(b[7:2]);
        if (din.final_byte) begin
          q_job.chars[1] = b64_char({b[1:0], 4'b0000});
          q_job.chars[2] = PAD_CHAR;
          q_job.chars[3] = PAD_CHAR;
          q_job.last_idx = 2'd3;
          q_job.ends_msg = 1'b1;
        end else begin
          q_job.last_idx = 2'd0;
          phase_next     = PH_SECOND;
          carry_next     = {2'b00, b[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      carry <= '0;
    end else if (q_push) begin
      phase <= phase_next;
      carry <= carry_next;
    end
  end

endmodule

[rtl/core/b64e_queue.sv]
// Short job queue between the front and back ends of the Base64 encoder.
// Depends on b64e_pkg.
module b64e_queue import b64e_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wr_job,
  output logic full,
  input  logic pop,
  output job_t rd_job,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/b64e_back.sv]
// Base64 encoder back end: steps each job one character per cycle, held
// by an unpopped result, into an output register with the oldest result.
// Depends on b64e_pkg.
module b64e_back import b64e_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  input  job_t      q_job,
  output logic      q_pop,
  output logic      empty,
  input  logic      pop,
  output out_item_t dout
);

  job_t       job;
  logic       job_valid;
  logic [1:0] idx;
  logic       out_valid;
  logic       pop_fire, move, job_done;

  assign pop_fire = pop && out_valid;
  assign move     = job_valid && (!out_valid || pop_fire);
  assign job_done = move && (idx == job.last_idx);
  assign q_pop    = !q_empty && (!job_valid || job_done);
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_job;
    end
    if (move) begin
      dout.out_char  <= job.chars[idx];
      dout.last_char <= job.ends_msg && (idx == job.last_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        job_valid <= 1'b1;
        idx       <= '0;
      end else if (job_done) begin
        job_valid <= 1'b0;
      end else if (move) begin
        idx <= idx + 1'b1;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (pop_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/base64_stream_encoder_top.sv]
// Top level of the Base64 stream encoder (standard alphabet, '=' padding).
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
//
//   channel   handshake          payload
//   input     push / full        din  : data_byte[7:0], final_byte
//   result    empty / pop        dout : out_char[7:0], last_char
//
// A byte is taken every cycle while the job queue has room; it yields one to
// four characters. The back end sends one character per cycle while results
// are popped, so the result channel sets the rate: four characters per three
// bytes of a group, plus the padding characters on the final byte. The result
// stays on dout until popped while bytes keep arriving into the queue. Reset
// clears the group phase, the queue and the output register.
module base64_stream_encoder_top import b64e_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  din,
  output logic      empty,
  input  logic      pop,
  output out_item_t dout
);

  logic q_push, q_pop, q_empty;
  job_t wr_job, rd_job;

  b64e_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .din    (din),
    .q_full (full),
    .q_push (q_push),
    .q_job  (wr_job)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_job (wr_job),
    .full   (full),
    .pop    (q_pop),
    .rd_job (rd_job),
    .empty  (q_empty)
  );

  b64e_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_job   (rd_job),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .dout    (dout)
  );

endmodule

[rtl/core/b64e_checker.sv]
// Port-level checks for the Base64 stream encoder, bound to its top level.
// Depends on b64e_pkg and base64_stream_encoder_top.
module b64e_checker import b64e_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      empty,
  input logic      pop,
  input out_item_t dout
);

  logic [1:0] grp_pos;
  logic       pop_fire;
  logic [7:0] c;

  assign pop_fire = pop && !empty;
  assign c        = dout.out_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_pos <= '0;
    end else if (pop_fire) begin
      grp_pos <= dout.last_char ? 2'd0 : grp_pos + 1'b1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(dout)))
    else $error("waiting result changed before pop");

  a_whole_group: assert property (@(posedge clk) disable iff (rst)
    (pop_fire && dout.last_char) |-> (grp_pos == 2'd3))
    else $error("message did not end on a whole four-character group");

  a_pad_place: assert property (@(posedge clk) disable iff (rst)
    (pop_fire && c == PAD_CHAR) |-> grp_pos[1])
    else $error("padding outside the last two places of a group");

  a_char_set: assert property (@(posedge clk) disable iff (rst)
    pop_fire |-> ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                  (c >= 8'h30 && c <= 8'h39) || c == 8'h2B || c == 8'h2F ||
                  c == PAD_CHAR))
    else $error("character outside the Base64 set");

endmodule

bind base64_stream_encoder_top b64e_checker u_b64e_checker (
  .clk   (clk),
  .rst   (rst),
  .empty (empty),
  .pop   (pop),
  .dout  (dout)
);

[sim/base64_stream_encoder_top_tb.sv]
// Self-checking testbench for base64_stream_encoder_top: a directed table, then random messages.
// Output checked against typed strings or an in-bench Base64 encoder, random stalls both sides.
// Depends on b64e_pkg and the encoder RTL.
module base64_stream_encoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import b64e_pkg::*;

  localparam int RANDOM_ITEMS = 400;
  localparam int CALM_ITEMS   = 60;
  localparam int HOLD_TRIGGER = 120;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic [0:63][7:0] B64_DIGITS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct {
    in_item_t item;
    string    typed;
  } row_t;

  logic      clk  = 1'b0;
  logic      rst  = 1'b1;
  logic      push = 1'b0;
  logic      pop  = 1'b0;
  in_item_t  din  = '0;
  logic      full;
  logic      empty;
  out_item_t dout;

  phase_t     grp_phase;
  logic [3:0] grp_carry;
  out_item_t  pending_chars[$];
  out_item_t  want;
  row_t       rows[$];
  int         errors   = 0;
  int         accepted = 0;
  int         cycles   = 0;
  bit         calm     = 1'b0;

  base64_stream_encoder_top dut (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .din  (din),
    .empty(empty),
    .pop  (pop),
    .dout (dout)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] digit(input logic [5:0] code);
    return B64_DIGITS[code];
  endfunction

  function void emit(input logic [7:0] ch, input logic last, input bit keep);
    out_item_t r;
    r.out_char  = ch;
    r.last_char = last;
    if (keep) pending_chars.push_back(r);
  endfunction

  function void encode_byte(input in_item_t it, input bit keep);
    logic [7:0] b;
    logic       fin;
    b   = it.data_byte;
    fin = it.final_byte;
    case (grp_phase)
      PH_SECOND: begin
        emit(digit({grp_carry[1:0], b[7:4]}), 1'b0, keep);
        if (fin) begin
          emit(digit({b[3:0], 2'b00}), 1'b0, keep);
          emit(PAD_CHAR, 1'b1, keep);
          grp_phase = PH_START;
          grp_carry = '0;
        end else begin
          grp_phase = PH_THIRD;
          grp_carry = b[3:0];
        end
      end
      PH_THIRD: begin
        emit(digit({grp_carry, b[7:6]}), 1'b0, keep);
        emit(digit(b[5:0]), fin, keep);
        grp_phase = PH_START;
        grp_carry = '0;
      end
      default: begin
        emit(digit(b[7:2]), 1'b0, keep);
        if (fin) begin
          emit(digit({b[1:0], 4'b0000}), 1'b0, keep);
          emit(PAD_CHAR, 1'b0, keep);
          emit(PAD_CHAR, 1'b1, keep);
          grp_phase = PH_START;
          grp_carry = '0;
        end else begin
          grp_phase = PH_SECOND;
          grp_carry = {2'b00, b[1:0]};
        end
      end
    endcase
  endfunction

  function void add_row(input logic [7:0] b, input logic fin, input string s);
    row_t r;
    r.item.data_byte  = b;
    r.item.final_byte = fin;
    r.typed           = s;
    rows.push_back(r);
  endfunction

  task offer(input in_item_t it);
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    push <= 1'b1;
    din  <= it;
    do @(posedge clk); while (full);
    accepted++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("base64_stream_encoder_top_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected request out, actual char=%h last=%b",
                 $time, dout.out_char, dout.last_char);
        errors++;
      end else begin
        want = pending_chars.pop_front();
        if (dout.out_char !== want.out_char || dout.last_char !== want.last_char) begin
          $display("%0t: mismatch, expected char=%h last=%b, actual char=%h last=%b",
                   $time, want.out_char, want.last_char, dout.out_char, dout.last_char);
          errors++;
        end
      end
    end
  end

  initial begin : receiver
    bit held;
    held = 1'b0;
    @(negedge rst);
    forever begin
      if (!held && accepted >= HOLD_TRIGGER) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : sender
    in_item_t it;
    int       sent;
    int       len;
    grp_phase = PH_START;
    grp_carry = '0;
    sent      = 0;

    add_row(8'h00, 1'b1, "AA==");
    add_row(8'hFF, 1'b1, "/w==");
    add_row(8'h00, 1'b0, "A");
    add_row(8'h00, 1'b1, "AA=");
    add_row(8'hFF, 1'b0, "/");
    add_row(8'hFF, 1'b0, "/");
    add_row(8'hFF, 1'b1, "//");
    add_row(8'hFB, 1'b0, "+");
    add_row(8'hEF, 1'b0, "+");
    add_row(8'hBE, 1'b1, "++");
    add_row(8'h80, 1'b1, "gA==");
    add_row("M", 1'b0, "");
    add_row("a", 1'b0, "");
    add_row("n", 1'b0, "");
    add_row("h", 1'b0, "");
    add_row("e", 1'b0, "");
    add_row("l", 1'b0, "");
    add_row("l", 1'b0, "");
    add_row("o", 1'b1, "");
    add_row(8'h01, 1'b0, "");
    add_row(8'hFE, 1'b1, "");

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      offer(rows[i].item);
      if (rows[i].typed.len() == 0) begin
        encode_byte(rows[i].item, 1'b1);
      end else begin
        encode_byte(rows[i].item, 1'b0);
        for (int k = 0; k < rows[i].typed.len(); k++)
          emit(rows[i].typed[k], rows[i].item.final_byte && k == rows[i].typed.len() - 1, 1'b1);
      end
    end

    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        it.data_byte  = 8'($urandom_range(0, 255));
        it.final_byte = 1'($urandom_range(0, 1));
        offer(it);
        encode_byte(it, 1'b1);
        sent++;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          it.data_byte  = 8'($urandom_range(0, 255));
          it.final_byte = (k == len - 1);
          offer(it);
          encode_byte(it, 1'b1);
          sent++;
        end
      end
      calm = (sent >= RANDOM_ITEMS - CALM_ITEMS);
    end

    push <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("base64_stream_encoder_top_tb: clean");
    end else begin
      $display("base64_stream_encoder_top_tb: errors");
    end
    $finish;
  end

endmodule
